/* src/bpns_pkg.sv */
package bpns_pkg;

    localparam int CORDIC_STAGES = 32;
    localparam int CS_W          = $clog2(CORDIC_STAGES + 1);

    localparam logic [63:0] SMAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;
    localparam logic [63:0] LN2_X31 = 64'd92288378632;   // 31*ln2, exp saturates here
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [63:0] COS_MIN_Q30 = 64'sd1073742;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD     = 3'd1;
    localparam logic [2:0] ST_VERT    = 3'd2;
    localparam logic [2:0] ST_FLAT    = 3'd3;
    localparam logic [2:0] ST_NOCONV  = 3'd4;

    // register indexes
    localparam logic [2:0] CFG_GRAVITY  = 3'd0;
    localparam logic [2:0] CFG_DRAG     = 3'd1;
    localparam logic [2:0] CFG_TOL      = 3'd2;
    localparam logic [2:0] CFG_MAX_STEP = 3'd3;
    localparam logic [2:0] CFG_PITCH    = 3'd4;
    localparam logic [2:0] CFG_MAX_ITER = 3'd5;

    // cordic modes
    localparam logic CM_VECTOR = 1'b0;
    localparam logic CM_ROTATE = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_cordic_req;

    function automatic logic [31:0] f_atan(input logic [CS_W-1:0] i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // rounded Q32.32 product from a raw magnitude product, saturating
    function automatic logic signed [63:0] f_smul_fin(input logic [127:0] p,
                                                      input logic neg);
        logic [127:0] r;
        logic [63:0]  m;
        r = p + 128'h8000_0000;
        if (|r[127:95]) m = SMAX;
        else            m = r[95:32];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] f_sadd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [64:0] lim;
        s   = {a[63], a} + {b[63], b};
        lim = $signed({1'b0, SMAX});
        if (s > lim)  return $signed(SMAX);
        if (s < -lim) return -$signed(SMAX);
        return s[63:0];
    endfunction

endpackage

/* src/bpns_in_if.sv */
interface bpns_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] muzzle_speed;
    logic signed [31:0] distance;
    logic signed [31:0] height;

    modport source (output valid, muzzle_speed, distance, height, input ready);
    modport sink   (input valid, muzzle_speed, distance, height, output ready);
endinterface

/* src/bpns_out_if.sv */
interface bpns_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] launch_pitch;
    logic [31:0]        flight_time;
    logic [2:0]         status;

    modport source (output valid, launch_pitch, flight_time, status, input ready);
    modport sink   (input valid, launch_pitch, flight_time, status, output ready);
endinterface

/* src/bpns_cfg_if.sv */
interface bpns_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [31:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

/* src/bpns_mul.sv */
// 64x64 unsigned multiply, one 32x32 partial product per cycle
module bpns_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    import bpns_pkg::*;

    logic [63:0]  r_a, r_b;
    logic [127:0] r_acc;
    logic [1:0]   r_cnt;
    logic         r_busy, r_done;
    logic [31:0]  w_pa, w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    always_comb begin
        w_pa = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        w_pb = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        w_pp = w_pa * w_pb;
        case (r_cnt)
            2'd0:    w_sh = {64'b0, w_pp};
            2'd3:    w_sh = {w_pp, 64'b0};
            default: w_sh = {32'b0, w_pp, 32'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= 2'd0;
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_acc  <= r_acc + w_sh;
                r_cnt  <= r_cnt + 2'd1;
                r_busy <= (r_cnt != 2'd3);
                r_done <= (r_cnt == 2'd3);
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

/* src/bpns_div.sv */
// 128/64 unsigned restoring divide, one quotient bit per cycle; quotient
// saturates to SMAX, overflow and zero divisor handled up front
module bpns_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_num,
    input  logic [63:0]  i_den,
    output logic         o_done,
    output logic [63:0]  o_quo
);
    import bpns_pkg::*;

    logic [63:0] r_rem, r_lo, r_quo, r_den;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] w_r65, w_sub;
    logic        w_ge, w_ovf;

    always_comb begin
        w_r65 = {r_rem, r_lo[63]};
        w_ge  = w_r65 >= {1'b0, r_den};
        w_sub = w_r65 - {1'b0, r_den};
        w_ovf = (i_den == 64'd0) || (i_num[127:64] >= i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_den  <= i_den;
                r_lo   <= i_num[63:0];
                r_rem  <= i_num[127:64];
                r_cnt  <= '0;
                r_done <= w_ovf;
                r_busy <= !w_ovf;
                if (w_ovf) begin
                    r_quo <= (i_num == 128'd0) ? 64'd0 : SMAX;
                end else begin
                    r_quo <= '0;
                end
            end else if (r_busy) begin
                r_lo   <= {r_lo[62:0], 1'b0};
                r_rem  <= w_ge ? w_sub[63:0] : w_r65[63:0];
                r_quo  <= {r_quo[62:0], w_ge};
                r_cnt  <= r_cnt + 7'd1;
                r_busy <= (r_cnt != 7'd63);
                r_done <= (r_cnt == 7'd63);
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo[63] ? SMAX : r_quo;
endmodule

/* src/bpns_cordic.sv */
// iterative CORDIC, one micro-rotation per cycle
// vectoring: drives y toward zero, z collects the angle
// rotation: drives z toward zero from the starting angle
module bpns_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bpns_pkg::t_cordic_req i_req,
    input  logic signed [63:0]    i_x,
    input  logic signed [63:0]    i_y,
    input  logic signed [35:0]    i_z,
    output logic                  o_done,
    output logic signed [63:0]    o_x,
    output logic signed [63:0]    o_y,
    output logic signed [35:0]    o_z
);
    import bpns_pkg::*;

    logic signed [63:0] r_x, r_y;
    logic signed [35:0] r_z;
    logic [CS_W-1:0]    r_i;
    logic               r_mode, r_busy, r_done;
    logic signed [63:0] w_xs, w_ys;
    logic signed [35:0] w_a;
    logic               w_pos, w_last;

    always_comb begin
        w_xs   = r_x >>> r_i;
        w_ys   = r_y >>> r_i;
        w_a    = $signed({4'b0, f_atan(r_i)});
        w_pos  = (r_mode == CM_ROTATE) ? (r_z >= 0) : !(r_y > 0);
        w_last = (r_i == CS_W'(CORDIC_STAGES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            if (i_req.start) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= i_z;
                r_mode <= i_req.mode;
                r_i    <= '0;
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                if (w_pos) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_a;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_a;
                end
                r_i    <= r_i + CS_W'(1);
                r_busy <= !w_last;
                r_done <= w_last;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule

/* src/ballistic_pitch_newton_solver_core.sv */
// Ballistic launch-pitch solver, quadratic horizontal drag, Newton iteration.
//
// Channels: i_req takes one request (muzzle_speed, distance, height, signed
// Q16.16); o_rsp returns one result (launch_pitch Q2.30, flight_time Q16.16,
// status). i_cfg writes the six registers by index; it is always ready and
// must only be written while the solver is idle.
//
// Structure: a request is worked on by a small sequencer that drives one shared
// 64x64 multiplier, one 128/64 divider (which finishes early when it saturates)
// and one CORDIC unit. The ln2 range reduction is a compare-and-subtract loop.
// Setup (exp series with up to 38 terms, drag coefficient, initial atan2) comes
// first; each Newton step costs 4 divides, 6 products and one CORDIC pass. One
// request is in flight at a time and i_req.ready is high only while the
// sequencer is idle.
//
// Reset restores the register defaults and empties the result register.
// A finished result sits in the output register; the sequencer is free for
// the next request as soon as it is loaded. If the receiver stalls and the
// output register is still full, the next result waits in the sequencer.
module ballistic_pitch_newton_solver_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bpns_in_if.sink         i_req,
    bpns_out_if.source      o_rsp,
    bpns_cfg_if.sink        i_cfg
);
    import bpns_pkg::*;

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_MUL_KD  = 5'd1;
    localparam logic [4:0] S_MUL_P   = 5'd2;
    localparam logic [4:0] S_DIV_N   = 5'd3;
    localparam logic [4:0] S_EXP_CHK = 5'd4;
    localparam logic [4:0] S_EXP_MUL = 5'd5;
    localparam logic [4:0] S_EXP_DIV = 5'd6;
    localparam logic [4:0] S_DIV_CC  = 5'd7;
    localparam logic [4:0] S_DIV_CC0 = 5'd8;
    localparam logic [4:0] S_ATAN    = 5'd9;
    localparam logic [4:0] S_MUL_VC  = 5'd10;
    localparam logic [4:0] S_MUL_G1  = 5'd11;
    localparam logic [4:0] S_MUL_G2  = 5'd12;
    localparam logic [4:0] S_MUL_H1  = 5'd13;
    localparam logic [4:0] S_MUL_H2  = 5'd14;
    localparam logic [4:0] S_ITER    = 5'd15;
    localparam logic [4:0] S_SINCOS  = 5'd16;
    localparam logic [4:0] S_DIV_TN  = 5'd17;
    localparam logic [4:0] S_MUL_CC2 = 5'd18;
    localparam logic [4:0] S_DIV_SEC = 5'd19;
    localparam logic [4:0] S_DIV_TT  = 5'd20;
    localparam logic [4:0] S_MUL_F1  = 5'd21;
    localparam logic [4:0] S_MUL_F2  = 5'd22;
    localparam logic [4:0] S_MUL_D1  = 5'd23;
    localparam logic [4:0] S_MUL_D2  = 5'd24;
    localparam logic [4:0] S_MUL_D3  = 5'd25;
    localparam logic [4:0] S_DIV_ST  = 5'd26;
    localparam logic [4:0] S_FIN     = 5'd27;

    // configuration
    logic [31:0] r_gravity, r_drag, r_tol;
    logic [30:0] r_max_step, r_pitch_lim;
    logic [6:0]  r_max_iter;

    // request and working state
    logic [4:0]         r_state;
    logic               r_iss;
    logic signed [31:0] r_v0, r_d, r_h, r_theta;
    logic [63:0]        r_x, r_p, r_rr, r_term, r_sum, r_e;
    logic [5:0]         r_j;
    logic [4:0]         r_n;
    logic [6:0]         r_it;
    logic signed [63:0] r_cc, r_vc, r_gcc, r_hgcc, r_tmp, r_sw, r_cw;
    logic signed [63:0] r_tn, r_sec, r_tt, r_acc, r_f;
    logic [2:0]         r_res_st;
    logic signed [31:0] r_res_pitch;
    logic [31:0]        r_res_time;

    // output register
    logic               r_ov;
    logic signed [31:0] r_o_pitch;
    logic [31:0]        r_o_time;
    logic [2:0]         r_o_st;

    // shared units
    logic               w_mul_go, w_mul_done, w_mul_neg;
    logic signed [63:0] w_ma, w_mb;
    logic [127:0]       w_prod;
    logic signed [63:0] w_smul;
    logic               w_div_go, w_div_done, w_div_neg;
    logic [127:0]       w_num;
    logic [63:0]        w_den, w_quo;
    logic signed [63:0] w_sdiv;
    t_cordic_req        w_creq;
    logic               w_cor_done;
    logic signed [63:0] w_cx0, w_cy0, w_cx, w_cy;
    logic signed [35:0] w_cz0, w_cz;

    // derived values
    logic signed [35:0] w_th36, w_fold;
    logic               w_fold_neg;
    logic signed [63:0] w_cq, w_sq;
    logic signed [63:0] w_step, w_msl, w_df;
    logic signed [64:0] w_thn, w_pl;
    logic [63:0]        w_kd, w_ee, w_tr;
    logic [47:0]        w_t16;
    logic               w_in_acc, w_can_load;

    assign w_in_acc   = i_req.valid && i_req.ready;
    assign w_can_load = !r_ov || o_rsp.ready;

    assign i_req.ready  = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_rsp.valid        = r_ov;
    assign o_rsp.launch_pitch = r_o_pitch;
    assign o_rsp.flight_time  = r_o_time;
    assign o_rsp.status       = r_o_st;

    // multiplier operand select
    always_comb begin
        w_mul_go = 1'b0;
        w_ma     = '0;
        w_mb     = '0;
        case (r_state)
            S_MUL_KD:  begin w_ma = {32'b0, r_drag}; w_mb = {{32{r_d[31]}}, r_d}; end
            S_MUL_P:   begin w_ma = {32'b0, r_drag}; w_mb = {{32{r_v0[31]}}, r_v0}; end
            S_EXP_MUL: begin w_ma = r_term; w_mb = r_rr; end
            S_MUL_VC:  begin w_ma = {{16{r_v0[31]}}, r_v0, 16'b0}; w_mb = r_cc; end
            S_MUL_G1:  begin w_ma = {24'b0, r_gravity, 8'b0}; w_mb = r_cc; end
            S_MUL_G2:  begin w_ma = r_tmp; w_mb = r_cc; end
            S_MUL_H1:  begin w_ma = {25'b0, r_gravity, 7'b0}; w_mb = r_cc; end
            S_MUL_H2:  begin w_ma = r_tmp; w_mb = r_cc; end
            S_MUL_CC2: begin w_ma = r_cw; w_mb = r_cw; end
            S_MUL_F1:  begin w_ma = r_vc; w_mb = r_tn; end
            S_MUL_F2:  begin w_ma = r_hgcc; w_mb = r_sec; end
            S_MUL_D1:  begin w_ma = r_vc; w_mb = r_sec; end
            S_MUL_D2:  begin w_ma = r_gcc; w_mb = r_tn; end
            S_MUL_D3:  begin w_ma = r_tmp; w_mb = r_sec; end
            default:   begin w_ma = '0; w_mb = '0; end
        endcase
        case (r_state)
            S_MUL_KD, S_MUL_P, S_EXP_MUL, S_MUL_VC, S_MUL_G1, S_MUL_G2,
            S_MUL_H1, S_MUL_H2, S_MUL_CC2, S_MUL_F1, S_MUL_F2, S_MUL_D1,
            S_MUL_D2, S_MUL_D3: w_mul_go = !r_iss;
            default:            w_mul_go = 1'b0;
        endcase
        w_mul_neg = w_ma[63] ^ w_mb[63];
        w_smul    = f_smul_fin(w_prod, w_mul_neg);
    end

    // divider operand select; signed quotients are sdiv(a, b, sh)
    always_comb begin
        w_div_go  = 1'b0;
        w_div_neg = 1'b0;
        w_num     = '0;
        w_den     = '0;
        case (r_state)
            S_EXP_DIV: begin w_num = {64'b0, r_x}; w_den = {58'b0, r_j}; end
            S_DIV_CC:  begin w_num = {16'b0, r_e, 48'b0}; w_den = r_p; end
            S_DIV_CC0: begin w_num = {64'b0, r_d, 32'b0}; w_den = {32'b0, r_v0}; end
            S_DIV_TN: begin
                w_num = {32'b0, f_mag(r_sw), 32'b0};
                w_den = f_mag(r_cw);
                w_div_neg = r_sw[63] ^ r_cw[63];
            end
            S_DIV_SEC: begin
                w_num = {63'b0, 1'b1, 64'b0};
                w_den = f_mag(r_tmp);
                w_div_neg = r_tmp[63];
            end
            S_DIV_TT: begin
                w_num = {32'b0, f_mag(r_cc), 32'b0};
                w_den = f_mag(r_cw);
                w_div_neg = r_cc[63] ^ r_cw[63];
            end
            S_DIV_ST: begin
                w_num = {34'b0, f_mag(r_f), 30'b0};
                w_den = f_mag(r_acc);
                w_div_neg = r_f[63] ^ r_acc[63];
            end
            default: begin w_num = '0; w_den = '0; end
        endcase
        case (r_state)
            S_EXP_DIV, S_DIV_CC, S_DIV_CC0, S_DIV_TN, S_DIV_SEC,
            S_DIV_TT, S_DIV_ST: w_div_go = !r_iss;
            default:            w_div_go = 1'b0;
        endcase
        w_sdiv = w_div_neg ? -$signed(w_quo) : $signed(w_quo);
    end

    // CORDIC setup: vectoring for the start angle, rotation with a fold by pi
    always_comb begin
        w_th36     = {{4{r_theta[31]}}, r_theta};
        w_fold_neg = 1'b0;
        w_fold     = w_th36;
        if (w_th36 > HALF_PI_Q30) begin
            w_fold     = w_th36 - PI_Q30;
            w_fold_neg = 1'b1;
        end else if (w_th36 < -HALF_PI_Q30) begin
            w_fold     = w_th36 + PI_Q30;
            w_fold_neg = 1'b1;
        end
        w_creq.mode  = (r_state == S_SINCOS) ? CM_ROTATE : CM_VECTOR;
        w_creq.start = (r_state == S_SINCOS || r_state == S_ATAN) && !r_iss;
        if (r_state == S_SINCOS) begin
            w_cx0 = $signed({4'b0, 30'd652032874, 30'b0});
            w_cy0 = '0;
            w_cz0 = w_fold;
        end else begin
            w_cx0 = {{3{r_d[31]}}, r_d, 29'b0};
            w_cy0 = {{3{r_h[31]}}, r_h, 29'b0};
            w_cz0 = '0;
        end
        // round back to Q2.30, undo the fold
        w_cq = (w_cx + 64'sd536870912) >>> 30;
        w_sq = (w_cy + 64'sd536870912) >>> 30;
        if (w_fold_neg) begin
            w_cq = -w_cq;
            w_sq = -w_sq;
        end
    end

    // step and pitch clamps, rounding of the flight time, derivative sum, kd and exp result
    always_comb begin
        w_df   = f_sadd(r_acc, w_smul);
        w_msl  = $signed({33'b0, r_max_step});
        w_step = w_sdiv;
        if (w_step > w_msl)       w_step = w_msl;
        else if (w_step < -w_msl) w_step = -w_msl;
        w_pl  = $signed({34'b0, r_pitch_lim});
        w_thn = {{33{r_theta[31]}}, r_theta} - {w_step[63], w_step};
        if (w_thn > w_pl)       w_thn = w_pl;
        else if (w_thn < -w_pl) w_thn = -w_pl;
        w_kd  = (w_prod[63:0] + 64'h8000) >> 16;
        w_ee  = ((r_sum + ONE_Q32) << r_n) - ONE_Q32;
        w_tr  = 64'(r_tt) + 64'h8000;
        w_t16 = w_tr[63:16];
    end

    bpns_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_go),
        .i_a     (f_mag(w_ma)),
        .i_b     (f_mag(w_mb)),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    bpns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    bpns_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_creq),
        .i_x     (w_cx0),
        .i_y     (w_cy0),
        .i_z     (w_cz0),
        .o_done  (w_cor_done),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_z     (w_cz)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= 32'd164136537;
            r_drag      <= 32'd40785224;
            r_tol       <= 32'd42950;
            r_max_step  <= 31'd107374182;
            r_pitch_lim <= 31'd1503238554;
            r_max_iter  <= 7'd30;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.addr)
                CFG_GRAVITY:  r_gravity   <= i_cfg.data;
                CFG_DRAG:     r_drag      <= i_cfg.data;
                CFG_TOL:      r_tol       <= i_cfg.data;
                CFG_MAX_STEP: r_max_step  <= i_cfg.data[30:0];
                CFG_PITCH:    r_pitch_lim <= i_cfg.data[30:0];
                CFG_MAX_ITER: r_max_iter  <= i_cfg.data[6:0];
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (r_state == S_FIN && w_can_load) begin
                r_ov      <= 1'b1;
                r_o_pitch <= r_res_pitch;
                r_o_time  <= r_res_time;
                r_o_st    <= r_res_st;
            end else if (r_ov && o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iss   <= 1'b0;
        end else begin
            if (w_mul_done || w_div_done || w_cor_done) r_iss <= 1'b0;
            else if (w_mul_go || w_div_go || w_creq.start) r_iss <= 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_v0        <= i_req.muzzle_speed;
                        r_d         <= i_req.distance;
                        r_h         <= i_req.height;
                        r_res_pitch <= '0;
                        r_res_time  <= '0;
                        if (i_req.muzzle_speed <= 0 || i_req.distance <= 0) begin
                            r_res_st <= ST_BAD;
                            r_state  <= S_FIN;
                        end else if (r_drag == 32'd0) begin
                            r_state <= S_DIV_CC0;
                        end else begin
                            r_state <= S_MUL_KD;
                        end
                    end
                end
                S_MUL_KD: if (w_mul_done) begin
                    r_x     <= w_kd;
                    r_n     <= '0;
                    r_state <= S_MUL_P;
                end
                S_MUL_P: if (w_mul_done) begin
                    r_p     <= w_prod[63:0];
                    r_state <= S_DIV_N;
                end
                S_DIV_N: begin
                    // exp range reduction by ln2: subtract until below ln2; saturate from 31*ln2 up
                    if (r_x >= LN2_X31) begin
                        r_e     <= SMAX;
                        r_state <= S_DIV_CC;
                    end else if (r_x >= LN2_Q32) begin
                        r_x <= r_x - LN2_Q32;
                        r_n <= r_n + 5'd1;
                    end else begin
                        r_rr    <= r_x;
                        r_term  <= r_x;
                        r_sum   <= '0;
                        r_j     <= 6'd2;
                        r_state <= S_EXP_CHK;
                    end
                end
                S_EXP_CHK: begin
                    if (r_j < 6'd40 && r_term != 64'd0) begin
                        r_sum   <= r_sum + r_term;
                        r_state <= S_EXP_MUL;
                    end else begin
                        r_e     <= w_ee;
                        r_state <= S_DIV_CC;
                    end
                end
                S_EXP_MUL: if (w_mul_done) begin
                    r_x     <= w_prod[95:32];
                    r_state <= S_EXP_DIV;
                end
                S_EXP_DIV: if (w_div_done) begin
                    r_term  <= w_quo;
                    r_j     <= r_j + 6'd1;
                    r_state <= S_EXP_CHK;
                end
                S_DIV_CC, S_DIV_CC0: if (w_div_done) begin
                    r_cc    <= $signed(w_quo);
                    r_state <= S_ATAN;
                end
                S_ATAN: if (w_cor_done) begin
                    r_theta <= w_cz[31:0];
                    r_state <= S_MUL_VC;
                end
                S_MUL_VC: if (w_mul_done) begin
                    r_vc    <= w_smul;
                    r_state <= S_MUL_G1;
                end
                S_MUL_G1: if (w_mul_done) begin
                    r_tmp   <= w_smul;
                    r_state <= S_MUL_G2;
                end
                S_MUL_G2: if (w_mul_done) begin
                    r_gcc   <= w_smul;
                    r_state <= S_MUL_H1;
                end
                S_MUL_H1: if (w_mul_done) begin
                    r_tmp   <= w_smul;
                    r_state <= S_MUL_H2;
                end
                S_MUL_H2: if (w_mul_done) begin
                    r_hgcc  <= w_smul;
                    r_it    <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (r_it >= r_max_iter) begin
                        r_res_st <= ST_NOCONV;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_SINCOS;
                    end
                end
                S_SINCOS: if (w_cor_done) begin
                    if (w_cq < COS_MIN_Q30 && w_cq > -COS_MIN_Q30) begin
                        r_res_st <= ST_VERT;
                        r_state  <= S_FIN;
                    end else begin
                        r_sw    <= w_sq <<< 2;
                        r_cw    <= w_cq <<< 2;
                        r_state <= S_DIV_TN;
                    end
                end
                S_DIV_TN: if (w_div_done) begin
                    r_tn    <= w_sdiv;
                    r_state <= S_MUL_CC2;
                end
                S_MUL_CC2: if (w_mul_done) begin
                    r_tmp   <= w_smul;
                    r_state <= S_DIV_SEC;
                end
                S_DIV_SEC: if (w_div_done) begin
                    r_sec   <= w_sdiv;
                    r_state <= S_DIV_TT;
                end
                S_DIV_TT: if (w_div_done) begin
                    r_tt    <= w_sdiv;
                    r_state <= S_MUL_F1;
                end
                S_MUL_F1: if (w_mul_done) begin
                    r_acc   <= f_sadd({{16{r_h[31]}}, r_h, 16'b0}, -w_smul);
                    r_state <= S_MUL_F2;
                end
                S_MUL_F2: if (w_mul_done) begin
                    r_f <= f_sadd(r_acc, w_smul);
                    // converged: residual height inside tolerance
                    if (f_mag(f_sadd(r_acc, w_smul)) < {32'b0, r_tol}) begin
                        r_res_st    <= ST_OK;
                        r_res_pitch <= r_theta;
                        if (r_tt > 0) begin
                            r_res_time <= (|w_t16[47:32]) ? 32'hFFFF_FFFF : w_t16[31:0];
                        end else begin
                            r_res_time <= '0;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MUL_D1;
                    end
                end
                S_MUL_D1: if (w_mul_done) begin
                    r_acc   <= -w_smul;
                    r_state <= S_MUL_D2;
                end
                S_MUL_D2: if (w_mul_done) begin
                    r_tmp   <= w_smul;
                    r_state <= S_MUL_D3;
                end
                S_MUL_D3: if (w_mul_done) begin
                    // r_acc holds the derivative from here on
                    r_acc <= w_df;
                    if (w_df == 64'sd0) begin
                        r_res_st <= ST_FLAT;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_DIV_ST;
                    end
                end
                S_DIV_ST: if (w_div_done) begin
                    r_theta <= w_thn[31:0];
                    r_it    <= r_it + 7'd1;
                    r_state <= S_ITER;
                end
                S_FIN: if (w_can_load) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* bench/bpns_aim_checker.sv */
`timescale 1ns / 100ps

module bpns_aim_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpns_in_if          req,
    bpns_out_if         rsp,
    bpns_cfg_if         cfg,
    output int          o_errors,
    output int          o_pending
);
    import bpns_pkg::*;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic [31:0]        tflight;
        logic [2:0]         status;
    } t_aim;

    localparam logic signed [63:0] S_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q32    = 64'sh1_0000_0000;
    localparam logic signed [63:0] HPI    = 64'sd1686629713;
    localparam logic signed [63:0] PI30   = 64'sd3373259426;
    localparam logic signed [63:0] GAIN30 = 64'sd652032874;
    localparam logic signed [63:0] COSMIN = 64'sd1073742;
    localparam logic [63:0]        LN2    = 64'd2977044472;

    localparam logic [31:0] ATAN_TBL [0:30] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001};

    logic [31:0] gravity, drag_k, tol;
    logic [30:0] step_lim, pitch_lim;
    logic [6:0]  iter_lim;
    t_aim        aim_q[$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = aim_q.size();

    function automatic logic signed [63:0] atan_at(input int i);
        return (i <= 30) ? $signed({32'h0, ATAN_TBL[i]}) : 64'sd0;
    endfunction

    function automatic logic [63:0] absv(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] signed_sat(input logic [63:0] m,
                                                      input logic neg);
        logic [63:0] c;
        c = (m > 64'(S_MAX)) ? 64'(S_MAX) : m;
        return neg ? -$signed(c) : $signed(c);
    endfunction

    function automatic logic [63:0] wide_div(input logic [63:0] hi, input logic [63:0] lo,
                                             input logic [63:0] den, input logic [63:0] lim);
        logic [127:0] q;
        if (den == 0 || hi >= den) return ((hi | lo) == 0) ? 64'd0 : lim;
        q = {hi, lo} / {64'd0, den};
        return (q[63:0] > lim) ? lim : q[63:0];
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic [127:0] p;
        p = {64'd0, absv(a)} * {64'd0, absv(b)} + 128'h8000_0000;
        if (|p[127:95]) return signed_sat(64'(S_MAX), a[63] != b[63]);
        return signed_sat(p[95:32], a[63] != b[63]);
    endfunction

    function automatic logic signed [63:0] qdiv(input logic signed [63:0] a,
                                                input logic signed [63:0] b, input int sh);
        logic [127:0] num;
        num = {64'd0, absv(a)} << sh;
        return signed_sat(wide_div(num[127:64], num[63:0], absv(b), 64'(S_MAX)),
                          a[63] != b[63]);
    endfunction

    function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(S_MAX)) return S_MAX;
        if (s < -65'(S_MAX)) return -S_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] clip(input logic signed [63:0] v,
                                                input logic signed [63:0] lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    function automatic logic signed [63:0] start_angle(input logic signed [63:0] y0,
                                                       input logic signed [63:0] x0);
        logic signed [63:0] x, y, z, xn;
        x = x0; y = y0; z = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (y > 0) begin
                xn = x + (y >>> i); y = y - (x >>> i); z = z + atan_at(i);
            end else begin
                xn = x - (y >>> i); y = y + (x >>> i); z = z - atan_at(i);
            end
            x = xn;
        end
        return z;
    endfunction

    function automatic void rotate(input logic signed [63:0] ang,
                                   output logic signed [63:0] s,
                                   output logic signed [63:0] c);
        logic signed [63:0] x, y, xn, th;
        logic               flip;
        x = GAIN30 * 64'sd1073741824; y = 0; th = ang; flip = 0;
        if (th > HPI) begin
            th = th - PI30; flip = 1;
        end else if (th < -HPI) begin
            th = th + PI30; flip = 1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (th >= 0) begin
                xn = x - (y >>> i); y = y + (x >>> i); th = th - atan_at(i);
            end else begin
                xn = x + (y >>> i); y = y - (x >>> i); th = th + atan_at(i);
            end
            x = xn;
        end
        c = (x + 64'sd536870912) >>> 30;
        s = (y + 64'sd536870912) >>> 30;
        if (flip) begin
            c = -c; s = -s;
        end
    endfunction

    // exp(x)-1 in Q32.32: reduce by ln2, then Taylor series
    function automatic logic [63:0] exp_minus_one(input logic [63:0] x);
        logic [63:0]  n, r, term, sum;
        logic [127:0] p;
        n = x / LN2;
        if (n >= 31) return 64'(S_MAX);
        r = x - n * LN2;
        term = r; sum = 0;
        for (int j = 2; j < 40 && term != 0; j++) begin
            sum = sum + term;
            p = {64'd0, term} * {64'd0, r};
            term = p[95:32] / 64'(j);
        end
        return ((sum + 64'(Q32)) << n) - 64'(Q32);
    endfunction

    function automatic t_aim solve_aim(input logic signed [31:0] vin,
                                       input logic signed [31:0] din,
                                       input logic signed [31:0] hin);
        t_aim               r;
        logic signed [63:0] v0, d, h, cc, theta, vc, gcc, hgcc;
        logic signed [63:0] sq, cq, sw, cw, tn, sec2, tt, f, df, stp;
        logic [63:0]        kd, p, e, t16;
        r = '{pitch: '0, tflight: '0, status: ST_NOCONV};
        v0 = 64'(vin); d = 64'(din); h = 64'(hin);
        if (v0 <= 0 || d <= 0) begin
            r.status = ST_BAD;
            return r;
        end
        if (drag_k == 0) begin
            cc = $signed({d[31:0], 32'h0} / 64'(v0));
        end else begin
            kd = ({32'h0, drag_k} * 64'(d) + 64'h8000) >> 16;
            p  = {32'h0, drag_k} * 64'(v0);
            e  = exp_minus_one(kd);
            cc = $signed(wide_div(e >> 16, e << 48, p, 64'(S_MAX)));
        end
        theta = start_angle(h * 64'sd536870912, d * 64'sd536870912);
        vc   = qmul(v0 * 64'sd65536, cc);
        gcc  = qmul(qmul($signed({24'h0, gravity, 8'h0}), cc), cc);
        hgcc = qmul(qmul($signed({25'h0, gravity, 7'h0}), cc), cc);
        for (int it = 0; it < iter_lim; it++) begin
            rotate(theta, sq, cq);
            if (cq < COSMIN && cq > -COSMIN) begin
                r.status = ST_VERT;
                return r;
            end
            sw = sq * 4; cw = cq * 4;
            tn   = qdiv(sw, cw, 32);
            sec2 = qdiv(Q32, qmul(cw, cw), 32);
            tt   = qdiv(cc, cw, 32);
            f  = qadd(qadd(h * 64'sd65536, -qmul(vc, tn)), qmul(hgcc, sec2));
            df = qadd(-qmul(vc, sec2), qmul(qmul(gcc, tn), sec2));
            if (absv(f) < {32'h0, tol}) begin
                t16 = 0;
                if (tt > 0) begin
                    t16 = (64'(tt) + 64'h8000) >> 16;
                    if (t16 > 64'hFFFF_FFFF) t16 = 64'hFFFF_FFFF;
                end
                r.pitch   = theta[31:0];
                r.tflight = t16[31:0];
                r.status  = ST_OK;
                return r;
            end
            if (df == 0) begin
                r.status = ST_FLAT;
                return r;
            end
            stp   = clip(qdiv(f, df, 30), $signed({33'h0, step_lim}));
            theta = clip(theta - stp, $signed({33'h0, pitch_lim}));
        end
        r.status = ST_NOCONV;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_aim want;
        if (!i_rst_n) begin
            gravity   <= 32'd164136537;
            drag_k    <= 32'd40785224;
            tol       <= 32'd42950;
            step_lim  <= 31'd107374182;
            pitch_lim <= 31'd1503238554;
            iter_lim  <= 7'd30;
            aim_q.delete();
            errors    = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.addr)
                    CFG_GRAVITY:  gravity   <= cfg.data;
                    CFG_DRAG:     drag_k    <= cfg.data;
                    CFG_TOL:      tol       <= cfg.data;
                    CFG_MAX_STEP: step_lim  <= cfg.data[30:0];
                    CFG_PITCH:    pitch_lim <= cfg.data[30:0];
                    CFG_MAX_ITER: iter_lim  <= cfg.data[6:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                aim_q.push_back(solve_aim(req.muzzle_speed, req.distance, req.height));
            if (rsp.valid && rsp.ready) begin
                if (aim_q.size() == 0) begin
                    $error("unexpected result: pitch %0d time %0d status %0d",
                           rsp.launch_pitch, rsp.flight_time, rsp.status);
                    errors++;
                end else begin
                    want = aim_q.pop_front();
                    if (rsp.launch_pitch !== want.pitch) begin
                        $error("launch_pitch: expected %0d, got %0d", want.pitch,
                               rsp.launch_pitch);
                        errors++;
                    end
                    if (rsp.flight_time !== want.tflight) begin
                        $error("flight_time: expected %0d, got %0d", want.tflight,
                               rsp.flight_time);
                        errors++;
                    end
                    if (rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import bpns_pkg::*;

    localparam longint CYCLE_LIMIT = 40_000_000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    int   tx_idle, rx_idle;     // idle percentages for sender and receiver
    int   hold_req;             // long receiver stall requested by stimulus
    longint cycles;

    bpns_in_if  req_if();
    bpns_out_if rsp_if();
    bpns_cfg_if cfg_if();

    ballistic_pitch_newton_solver_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    bpns_aim_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg       (cfg_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold;
        hold = 0;
        rsp_if.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                rsp_if.ready <= 0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    // one request; the sender may idle first
    task automatic send_shot(input logic [31:0] v, input logic [31:0] d,
                             input logic [31:0] h);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            req_if.valid <= 0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1;
        req_if.muzzle_speed <= v;
        req_if.distance     <= d;
        req_if.height       <= h;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        req_if.valid <= 0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 0;
    endtask

    task automatic set_regs(input logic [31:0] g, input logic [31:0] k,
                            input logic [31:0] tl, input logic [31:0] ms,
                            input logic [31:0] pl, input logic [31:0] mi);
        write_reg(CFG_GRAVITY, g);
        write_reg(CFG_DRAG, k);
        write_reg(CFG_TOL, tl);
        write_reg(CFG_MAX_STEP, ms);
        write_reg(CFG_PITCH, pl);
        write_reg(CFG_MAX_ITER, mi);
    endtask

    // every item yields exactly one result, so an empty queue means idle
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // mostly plausible shots with random fractions; the rest is raw noise
    task automatic random_shots(input int n);
        logic [31:0] v, d, h;
        int          pick;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                v = ($urandom_range(1200, 30) << 16) | $urandom_range(65535);
                d = ($urandom_range(3000, 1) << 16) | $urandom_range(65535);
                h = (($urandom_range(600) - 300) << 16) | $urandom_range(65535);
            end else if (pick < 85) begin
                v = $urandom & 32'h7FFF_FFFF;
                d = $urandom & 32'h7FFF_FFFF;
                h = $urandom;
            end else begin
                v = $urandom; d = $urandom; h = $urandom;
            end
            send_shot(v, d, h);
        end
        end_burst();
    endtask

    // edges: bad input, extremes, near vertical, huge range
    task automatic directed_shots();
        send_shot(32'd0, 32'd100 << 16, 32'd0);            // zero speed
        send_shot(32'h8000_0000, 32'd100 << 16, 32'd0);    // most negative speed
        send_shot(32'd300 << 16, 32'd0, 32'd0);            // zero range
        send_shot(32'd300 << 16, 32'hFFFF_FFFF, 32'd5);    // negative range
        send_shot(32'd300 << 16, 32'd200 << 16, 32'd0);    // level shot
        send_shot(32'd300 << 16, 32'd200 << 16, 32'd20 << 16);
        send_shot(32'd300 << 16, 32'd200 << 16, -(32'd20 << 16));
        send_shot(32'd800 << 16, 32'd1000 << 16, 32'd50 << 16);
        send_shot(32'd1, 32'd1, 32'd0);                     // smallest positives
        send_shot(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_shot(32'h7FFF_FFFF, 32'd1 << 16, 32'h8000_0000);
        send_shot(32'd100 << 16, 32'd1, 32'h7FFF_FFFF);     // start near vertical
        send_shot(32'd100 << 16, 32'd1, 32'h8000_0000);     // near vertical, down
        send_shot(32'd50 << 16, 32'h7FFF_FFFF, 32'd0);      // huge drag range
        send_shot(32'd20 << 16, 32'd100 << 16, 32'd0);      // out of reach
        send_shot(32'd5 << 16, 32'd500 << 16, 32'd0);       // out of reach
        send_shot(32'd300 << 16, 32'd10 << 16, 32'd9 << 16); // steep
        send_shot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        end_burst();
    endtask

    initial begin
        i_rst_n = 0;
        tx_idle = 29;
        rx_idle = 67;
        hold_req = 0;
        req_if.valid = 0;
        req_if.muzzle_speed = 0;
        req_if.distance = 0;
        req_if.height = 0;
        cfg_if.valid = 0;
        cfg_if.addr = CFG_GRAVITY;
        cfg_if.data = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // defaults from reset
        directed_shots();
        drain();

        // defaults written back explicitly; long stall so results back up
        set_regs(32'd164136537, 32'd40785224, 32'd42950, 32'd107374182,
                 32'd1503238554, 32'd30);
        hold_req = 40000;
        random_shots(55);
        drain();

        // sender idles more than receiver now
        tx_idle = 67;
        rx_idle = 29;
        // no drag, weakest gravity, loosest tolerance, widest limits
        set_regs(32'd1, 32'd0, 32'hFFFF_FFFF, 32'd1610612736, 32'd1686629713, 32'd64);
        directed_shots();
        random_shots(15);
        drain();

        // strongest gravity and drag, tightest limits
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1, 32'd1);
        random_shots(25);
        drain();

        tx_idle = 0;
        rx_idle = 0;
        // values beyond the nominal ranges: pitch past vertical, no steps
        set_regs(32'd164136537, 32'd40785224, 32'd42950, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'd40);
        random_shots(10);
        drain();
        write_reg(CFG_MAX_STEP, 32'd0);
        random_shots(4);
        drain();
        write_reg(CFG_MAX_ITER, 32'd0);
        random_shots(4);
        drain();

        // random plausible settings
        set_regs(32'd164136537 + $urandom_range(4000000) - 32'd2000000,
                 $urandom_range(80000000, 1), $urandom_range(4000000, 4000),
                 $urandom_range(300000000, 10000000), $urandom_range(1686629713, 1000000000),
                 $urandom_range(40, 5));
        random_shots(60);
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/bpns_pkg.sv
src/bpns_in_if.sv
src/bpns_out_if.sv
src/bpns_cfg_if.sv
src/bpns_mul.sv
src/bpns_div.sv
src/bpns_cordic.sv
src/ballistic_pitch_newton_solver_core.sv
bench/bpns_aim_checker.sv
bench/testbench.sv
